// ----- design/ptg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptg_pkg - shared types and constants of the pulse train generator
// Command codes, register map and the configuration bundle.
// ----------------------------------------------------------------------------
package ptg_pkg;

  typedef enum logic [1:0] {
    CMD_SERVICE = 2'd0,
    CMD_TRIGGER = 2'd1,
    CMD_CANCEL  = 2'd2
  } cmd_e;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned TOTAL_W    = 16;
  localparam int unsigned DUR_W      = 32;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_CYCLE_TOTAL = 2'd0,
    REG_FIRST_DELAY = 2'd1,
    REG_HIGH_TIME   = 2'd2,
    REG_LOW_TIME    = 2'd3
  } reg_e;

  typedef struct packed {
    logic [TOTAL_W-1:0] cycle_total;
    logic [DUR_W-1:0]   first_delay;
    logic [DUR_W-1:0]   high_time;
    logic [DUR_W-1:0]   low_time;
  } cfg_t;

endpackage

// ----- design/ptg_cmd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptg_cmd_if - command channel
// Valid/ready channel carrying one command word and the current tick.
// ----------------------------------------------------------------------------
interface ptg_cmd_if #(
  parameter int unsigned TICK_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic [ptg_pkg::CMD_W-1:0]   command;
  logic [TICK_BITS-1:0]        now_tick;

  modport source (output valid, output command, output now_tick, input ready);
  modport sink   (input valid, input command, input now_tick, output ready);
endinterface

// ----- design/ptg_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptg_res_if - result channel
// Valid/ready channel carrying one result word per command.
// ----------------------------------------------------------------------------
interface ptg_res_if;
  logic                        valid;
  logic                        ready;
  logic                        level;
  logic                        toggled;
  logic [ptg_pkg::INDEX_W-1:0] cycle_index;
  logic                        busy_res;

  modport source (output valid, output level, output toggled, output cycle_index,
                  output busy_res, input ready);
  modport sink   (input valid, input level, input toggled, input cycle_index,
                  input busy_res, output ready);
endinterface

// ----- design/ptg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptg_regs - configuration register file
// APB-style write/read of cycle total, first delay, high and low time.
// ----------------------------------------------------------------------------
module ptg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ptg_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [ptg_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ptg_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output ptg_pkg::cfg_t                      cfg_o
);

  ptg_pkg::cfg_t cfg_q;
  ptg_pkg::reg_e sel;
  logic          wr_en;

  assign pready = 1'b1;
  assign sel    = ptg_pkg::reg_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (sel)
        ptg_pkg::REG_CYCLE_TOTAL: cfg_q.cycle_total <= pwdata[ptg_pkg::TOTAL_W-1:0];
        ptg_pkg::REG_FIRST_DELAY: cfg_q.first_delay <= pwdata[ptg_pkg::DUR_W-1:0];
        ptg_pkg::REG_HIGH_TIME:   cfg_q.high_time   <= pwdata[ptg_pkg::DUR_W-1:0];
        ptg_pkg::REG_LOW_TIME:    cfg_q.low_time    <= pwdata[ptg_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      ptg_pkg::REG_CYCLE_TOTAL: prdata = ptg_pkg::APB_DATA_W'(cfg_q.cycle_total);
      ptg_pkg::REG_FIRST_DELAY: prdata = ptg_pkg::APB_DATA_W'(cfg_q.first_delay);
      ptg_pkg::REG_HIGH_TIME:   prdata = ptg_pkg::APB_DATA_W'(cfg_q.high_time);
      ptg_pkg::REG_LOW_TIME:    prdata = ptg_pkg::APB_DATA_W'(cfg_q.low_time);
      default:                  prdata = '0;
    endcase
  end

endmodule

// ----- design/ptg_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptg_core - pulse train channel datapath
// Input register, train state update and result register in one pass.
// ----------------------------------------------------------------------------
module ptg_core #(
  parameter int unsigned TICK_BITS  = 32,
  parameter int unsigned CYCLE_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ptg_pkg::cfg_t cfg_i,
  ptg_cmd_if.sink       cmd_i,
  ptg_res_if.source     res_o
);

  localparam int unsigned CMP_W = (TICK_BITS > ptg_pkg::DUR_W) ? TICK_BITS : ptg_pkg::DUR_W;
  localparam int unsigned CNT_W = (CYCLE_BITS > ptg_pkg::TOTAL_W) ? CYCLE_BITS
                                                                    : ptg_pkg::TOTAL_W;

  // input register
  logic                      in_valid_q;
  logic [ptg_pkg::CMD_W-1:0] cmd_q;
  logic [TICK_BITS-1:0]      tick_q;

  // train state
  logic                  running_q, running_d;
  logic                  level_q, level_d;
  logic [CYCLE_BITS-1:0] count_q, count_d;
  logic [TICK_BITS-1:0]  edge_q, edge_d;

  // result register
  logic                        out_valid_q;
  logic                        toggled_q, toggled_d;
  logic [ptg_pkg::INDEX_W-1:0] index_q, index_d;

  logic                  advance;
  logic [TICK_BITS-1:0]  elapsed;
  logic [ptg_pkg::DUR_W-1:0] dur;
  logic [CYCLE_BITS-1:0] count_inc;

  assign advance     = in_valid_q & (~out_valid_q | res_o.ready);
  assign cmd_i.ready = ~in_valid_q | advance;

  assign elapsed   = tick_q - edge_q;
  assign count_inc = count_q + CYCLE_BITS'(1);

  always_comb begin
    if (level_q) begin
      dur = cfg_i.high_time;
    end else if (count_q == '0) begin
      dur = cfg_i.first_delay;
    end else begin
      dur = cfg_i.low_time;
    end
  end

  always_comb begin
    running_d = running_q;
    level_d   = level_q;
    count_d   = count_q;
    edge_d    = edge_q;
    toggled_d = 1'b0;
    index_d   = '0;
    case (cmd_q)
      ptg_pkg::CMD_TRIGGER: begin
        if (cfg_i.cycle_total != '0) begin
          running_d = 1'b1;
          level_d   = 1'b0;
          count_d   = '0;
          edge_d    = tick_q;
        end
      end
      ptg_pkg::CMD_CANCEL: begin
        running_d = 1'b0;
      end
      ptg_pkg::CMD_SERVICE: begin
        if (running_q && (CMP_W'(elapsed) >= CMP_W'(dur))) begin
          level_d   = ~level_q;
          edge_d    = tick_q;
          toggled_d = 1'b1;
          index_d   = ptg_pkg::INDEX_W'(count_q);
          // falling edge closes the cycle
          if (level_q) begin
            count_d = count_inc;
            if (CNT_W'(count_inc) >= CNT_W'(cfg_i.cycle_total)) begin
              running_d = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      running_q   <= 1'b0;
      level_q     <= 1'b0;
      count_q     <= '0;
      edge_q      <= '0;
    end else begin
      if (cmd_i.ready) begin
        in_valid_q <= cmd_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        running_q   <= running_d;
        level_q     <= level_d;
        count_q     <= count_d;
        edge_q      <= edge_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      cmd_q  <= cmd_i.command;
      tick_q <= cmd_i.now_tick;
    end
    if (advance) begin
      toggled_q <= toggled_d;
      index_q   <= index_d;
    end
  end

  // state only moves when a result is loaded, so it doubles as the payload
  assign res_o.valid       = out_valid_q;
  assign res_o.level       = level_q;
  assign res_o.busy_res    = running_q;
  assign res_o.toggled     = toggled_q;
  assign res_o.cycle_index = index_q;

endmodule

// ----- design/pulse_train_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_train_generator - one pulse train channel
// Commands carrying the current tick start, service or cancel a train of
// high/low cycles; every command returns one result word.
// ----------------------------------------------------------------------------
//  channel   direction  word                                        handshake
//  cmd_i     in         command, now_tick                           valid/ready
//  res_o     out        level, toggled, cycle_index, busy_res       valid/ready
//  apb       in/out     cycle_total, first_delay, high/low time     psel/penable
//
//  A command is taken into the input register, evaluated against the train
//  state and loaded into the result register; one command per cycle is
//  sustained while the result register is free or its word is taken.
//  Reset clears the train state, the configuration registers and both valid flags.
//  A stalled result holds the input register; a free result register lets a
//  new command in every cycle.
// ----------------------------------------------------------------------------
module pulse_train_generator #(
  parameter int unsigned TICK_BITS  = 32,
  parameter int unsigned CYCLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ptg_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ptg_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ptg_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  // streams
  ptg_cmd_if.sink                        cmd_i,
  ptg_res_if.source                      res_o
);

  ptg_pkg::cfg_t cfg;

  // Hold configuration; registers are read live by the datapath.
  ptg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the train one command per cycle while results are taken.
  ptg_core #(
    .TICK_BITS  (TICK_BITS),
    .CYCLE_BITS (CYCLE_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (cmd_i),
    .res_o  (res_o)
  );

  // A rising edge never ends a train.
  a_rise_keeps_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.toggled && res_o.level) |-> res_o.busy_res)
    else $error("train stopped on a rising edge");

  // The cycle index is reported only with a toggle.
  a_index_only_on_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.toggled) |-> (res_o.cycle_index == '0))
    else $error("cycle index without toggle");

  // Hold a refused result word until it is taken.
  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready && !cmd_i.ready) |=> (res_o.valid))
    else $error("result dropped under stall");

  // A cancel always leaves the train stopped.
  a_cancel_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (u_core.advance && (u_core.cmd_q == ptg_pkg::CMD_CANCEL)) |=> !res_o.busy_res)
    else $error("cancel did not stop train");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench of the pulse train generator
// A scripted run of commands with hand-worked results walks the reset state,
// the extremes and the corner cases. Randomized phases follow, each with its
// own register setting. A command-level model of the train predicts each
// randomized result word, and a scoreboard compares each word field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned     TICK_BITS    = 32;
  localparam logic [1:0]      CMD_UNUSED   = 2'd3;   // not a defined command
  localparam int unsigned     PHASES       = 8;
  localparam int unsigned     PHASE_ITEMS  = 100;
  localparam int unsigned     SETTLE_TICKS = 4;      // settling margin after the last result
  localparam int unsigned     TAIL_TICKS   = 8;
  localparam int unsigned     SQUEEZE_LEN  = 300;    // long receiver hold-off
  localparam longint unsigned CYCLE_LIMIT  = 400000;

  // One result word as the bench sees it
  typedef struct packed {
    logic                        level;
    logic                        toggled;
    logic [ptg_pkg::INDEX_W-1:0] cycle_index;
    logic                        busy;
  } pulse_word_t;

  // One line of the scripted run: either a register write or a command word,
  // optionally with its result typed in by hand
  typedef struct {
    bit            is_cfg;
    ptg_pkg::reg_e sel;
    logic [31:0]   value;
    logic [1:0]    op;
    logic [31:0]   tick;
    bit            typed;
    pulse_word_t   want;
  } script_row_t;

  typedef struct {
    bit          typed;
    pulse_word_t want;
  } word_plan_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [ptg_pkg::APB_ADDR_W-1:0] paddr;
  logic [ptg_pkg::APB_DATA_W-1:0] pwdata;
  logic [ptg_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  ptg_cmd_if #(.TICK_BITS(TICK_BITS)) cmd_bus ();
  ptg_res_if                          res_bus ();

  pulse_train_generator #(
    .TICK_BITS  (TICK_BITS),
    .CYCLE_BITS (16)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd_i   (cmd_bus),
    .res_o   (res_bus)
  );

  // Model of the train: its own copy of the registers and the channel state
  ptg_pkg::cfg_t               cfg_shadow;
  logic                        trn_running;
  logic                        trn_level;
  logic [ptg_pkg::INDEX_W-1:0] trn_cycle;
  logic [31:0]                 trn_edge;

  pulse_word_t pulse_q[$];     // result words still owed by the block
  script_row_t script[$];
  word_plan_t  cur_plan;       // what goes with the word now on offer

  int          errors;
  int          words_in;
  int          words_out;
  int          toggles_seen;
  int          stall_cycles;
  int          settings_used;
  longint unsigned cycles;

  bit          tx_calm;
  bit          rx_calm;
  bit          squeeze_req;
  int          rx_hold;

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stop a hung run: the slowest legal run is far below this
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d result words still owed", $time, pulse_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Model of the channel: apply one command word, return the result word
  // --------------------------------------------------------------------------
  function automatic pulse_word_t advance_train(logic [1:0] op, logic [31:0] tick);
    pulse_word_t w;
    logic [31:0] elapsed;
    logic [31:0] span;
    w = '0;
    case (op)
      ptg_pkg::CMD_TRIGGER: begin
        // a zero cycle total ignores the trigger; otherwise restart low
        if (cfg_shadow.cycle_total != '0) begin
          trn_running = 1'b1;
          trn_level   = 1'b0;
          trn_cycle   = '0;
          trn_edge    = tick;
        end
      end
      ptg_pkg::CMD_CANCEL: begin
        trn_running = 1'b0;  // level stays where it is
      end
      ptg_pkg::CMD_SERVICE: begin
        if (trn_running) begin
          elapsed = tick - trn_edge;  // wraps modulo the tick width
          if (trn_level)
            span = cfg_shadow.high_time;
          else if (trn_cycle == '0)
            span = cfg_shadow.first_delay;
          else
            span = cfg_shadow.low_time;
          if (elapsed >= span) begin
            trn_level     = ~trn_level;
            trn_edge      = tick;
            w.toggled     = 1'b1;
            w.cycle_index = trn_cycle;
            // a falling edge closes the cycle; stop after the last one
            if (!trn_level) begin
              trn_cycle = trn_cycle + ptg_pkg::INDEX_W'(1);
              if (trn_cycle >= cfg_shadow.cycle_total)
                trn_running = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    w.level = trn_level;
    w.busy  = trn_running;
    return w;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predict on every accepted command, check every accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pulse_word_t calc;
    pulse_word_t got;
    pulse_word_t want;
    if (rst_ni) begin
      // predict first so that any latency, however short, is covered
      if (cmd_bus.valid && cmd_bus.ready) begin
        calc = advance_train(cmd_bus.command, cmd_bus.now_tick);
        pulse_q.push_back(cur_plan.typed ? cur_plan.want : calc);
        words_in++;
      end else if (cmd_bus.valid) begin
        stall_cycles++;
      end
      if (res_bus.valid && res_bus.ready) begin
        got.level       = res_bus.level;
        got.toggled     = res_bus.toggled;
        got.cycle_index = res_bus.cycle_index;
        got.busy        = res_bus.busy_res;
        words_out++;
        if (pulse_q.size() == 0) begin
          $display("%0t: result word with nothing owed, got %0h", $time, got);
          errors++;
        end else begin
          want = pulse_q.pop_front();
          check_field("level", 32'(want.level), 32'(got.level));
          check_field("toggled", 32'(want.toggled), 32'(got.toggled));
          check_field("cycle_index", 32'(want.cycle_index), 32'(got.cycle_index));
          check_field("busy_res", 32'(want.busy), 32'(got.busy));
          if (got.toggled === 1'b1)
            toggles_seen++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready, calm stretches, and one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int r;
    res_bus.ready = 1'b0;
    rx_hold       = 0;
    forever begin
      @(negedge clk_i);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        rx_hold     = SQUEEZE_LEN;
      end
      if (rx_hold > 0) begin
        // hold off and let the block back up into its input
        rx_hold--;
        res_bus.ready <= 1'b0;
      end else if (rx_calm) begin
        res_bus.ready <= 1'b1;
      end else begin
        r = $urandom_range(99);
        if (r < 72) begin
          res_bus.ready <= 1'b1;
        end else begin
          res_bus.ready <= 1'b0;
          rx_hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(7, 29);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap(bit calm);
    int r;
    if (calm)
      return 0;
    r = $urandom_range(99);
    if (r < 60)
      return 0;
    else if (r < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 30);
  endfunction

  // Offer one word and wait for it to be taken; leave valid high so that the
  // next word can follow in the very next cycle
  task automatic send_word(logic [1:0] op, logic [31:0] tick, bit typed, pulse_word_t want);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      @(negedge clk_i);
      cmd_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cur_plan.typed    = typed;
    cur_plan.want     = want;
    cmd_bus.valid    <= 1'b1;
    cmd_bus.command  <= op;
    cmd_bus.now_tick <= tick;
    do @(posedge clk_i); while (!(cmd_bus.valid && cmd_bus.ready));
  endtask

  // Drop valid and wait until every owed result word has come back
  task automatic drain();
    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
    while (pulse_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // Setup cycle, access cycle, then release the bus
  task automatic apb_access(bit wr, ptg_pkg::reg_e sel, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write a register, mirror it in the model, read it back
  task automatic set_register(ptg_pkg::reg_e sel, logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] rd;
    mask = (sel == ptg_pkg::REG_CYCLE_TOTAL) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
    apb_access(1'b1, sel, val & mask, rd);
    case (sel)
      ptg_pkg::REG_CYCLE_TOTAL: cfg_shadow.cycle_total = val[ptg_pkg::TOTAL_W-1:0];
      ptg_pkg::REG_FIRST_DELAY: cfg_shadow.first_delay = val;
      ptg_pkg::REG_HIGH_TIME:   cfg_shadow.high_time   = val;
      ptg_pkg::REG_LOW_TIME:    cfg_shadow.low_time    = val;
      default: ;
    endcase
    apb_access(1'b0, sel, '0, rd);
    if ((rd & mask) !== (val & mask)) begin
      $display("%0t: readback of %s, expected %0h, got %0h", $time, sel.name(), val & mask,
               rd & mask);
      errors++;
    end
  endtask

  // Script builders
  function automatic void add_cfg(ptg_pkg::reg_e sel, logic [31:0] val);
    script_row_t row;
    row.is_cfg = 1'b1;
    row.sel    = sel;
    row.value  = val;
    row.op     = '0;
    row.tick   = '0;
    row.typed  = 1'b0;
    row.want   = '0;
    script.push_back(row);
  endfunction

  function automatic void add_word(logic [1:0] op, logic [31:0] tick, int lvl, int tog,
                                   logic [ptg_pkg::INDEX_W-1:0] idx, int busy);
    script_row_t row;
    row.is_cfg = 1'b0;
    row.sel    = ptg_pkg::REG_CYCLE_TOTAL;
    row.value  = '0;
    row.op     = op;
    row.tick   = tick;
    row.typed  = 1'b1;
    row.want   = '{level: 1'(lvl), toggled: 1'(tog), cycle_index: idx, busy: 1'(busy)};
    script.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int            r;
    logic [1:0]    op;
    logic [31:0]   tick_now;
    logic [31:0]   tot, fd, ht, lt;
    ptg_pkg::reg_e pick;
    bit            mid_change;
    script_row_t   row;

    // drive every input from time zero
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    cmd_bus.valid    = 1'b0;
    cmd_bus.command  = ptg_pkg::CMD_SERVICE;
    cmd_bus.now_tick = '0;
    cur_plan         = '{typed: 1'b0, want: '0};
    tx_calm          = 1'b0;
    rx_calm          = 1'b0;
    squeeze_req      = 1'b0;
    errors           = 0;
    cycles           = 0;

    // model starts from the reset state
    cfg_shadow  = '0;
    trn_running = 1'b0;
    trn_level   = 1'b0;
    trn_cycle   = '0;
    trn_edge    = '0;

    // After reset: all registers zero, so triggers are ignored
    add_word(ptg_pkg::CMD_SERVICE, 32'h0000_0000, 0, 0, 16'd0, 0);
    add_word(ptg_pkg::CMD_TRIGGER, 32'h0000_0005, 0, 0, 16'd0, 0);
    add_word(CMD_UNUSED,           32'hFFFF_FFFF, 0, 0, 16'd0, 0);
    add_word(ptg_pkg::CMD_CANCEL,  32'h0000_0000, 0, 0, 16'd0, 0);
    // A train of two pulses worked by hand: delay 10, high 3, low 4
    add_cfg(ptg_pkg::REG_CYCLE_TOTAL, 32'd2);
    add_cfg(ptg_pkg::REG_FIRST_DELAY, 32'd10);
    add_cfg(ptg_pkg::REG_HIGH_TIME,   32'd3);
    add_cfg(ptg_pkg::REG_LOW_TIME,    32'd4);
    add_word(ptg_pkg::CMD_TRIGGER, 32'd100, 0, 0, 16'd0, 1);
    add_word(ptg_pkg::CMD_SERVICE, 32'd105, 0, 0, 16'd0, 1);
    add_word(ptg_pkg::CMD_SERVICE, 32'd110, 1, 1, 16'd0, 1);
    add_word(ptg_pkg::CMD_SERVICE, 32'd112, 1, 0, 16'd0, 1);
    add_word(ptg_pkg::CMD_SERVICE, 32'd113, 0, 1, 16'd0, 1);
    add_word(ptg_pkg::CMD_SERVICE, 32'd117, 1, 1, 16'd1, 1);
    add_word(CMD_UNUSED,           32'd0,   1, 0, 16'd0, 1);
    add_word(ptg_pkg::CMD_SERVICE, 32'd120, 0, 1, 16'd1, 0);
    add_word(ptg_pkg::CMD_SERVICE, 32'd200, 0, 0, 16'd0, 0);   // poll while idle
    // Extremes: longest delay reached across the tick wrap, zero durations
    add_cfg(ptg_pkg::REG_CYCLE_TOTAL, 32'h0000_FFFF);
    add_cfg(ptg_pkg::REG_FIRST_DELAY, 32'hFFFF_FFFF);
    add_cfg(ptg_pkg::REG_HIGH_TIME,   32'd0);
    add_cfg(ptg_pkg::REG_LOW_TIME,    32'd0);
    add_word(ptg_pkg::CMD_TRIGGER, 32'hFFFF_FFF0, 0, 0, 16'd0, 1);
    add_word(ptg_pkg::CMD_SERVICE, 32'hFFFF_FFEF, 1, 1, 16'd0, 1);
    add_word(ptg_pkg::CMD_SERVICE, 32'hFFFF_FFEF, 0, 1, 16'd0, 1);
    add_word(ptg_pkg::CMD_SERVICE, 32'h0000_0000, 1, 1, 16'd1, 1);
    add_word(ptg_pkg::CMD_TRIGGER, 32'h1234_5678, 0, 0, 16'd0, 1);   // restart while running
    add_word(ptg_pkg::CMD_SERVICE, 32'h1234_5679, 0, 0, 16'd0, 1);
    // Change registers with the train still running
    add_cfg(ptg_pkg::REG_FIRST_DELAY, 32'd0);
    add_cfg(ptg_pkg::REG_CYCLE_TOTAL, 32'd1);
    add_word(ptg_pkg::CMD_SERVICE, 32'h0000_0000, 1, 1, 16'd0, 1);
    add_word(ptg_pkg::CMD_SERVICE, 32'hFFFF_FFFF, 0, 1, 16'd0, 0);
    // Cancel while high keeps the level
    add_word(ptg_pkg::CMD_TRIGGER, 32'h0000_0000, 0, 0, 16'd0, 1);
    add_word(ptg_pkg::CMD_SERVICE, 32'h0000_0000, 1, 1, 16'd0, 1);
    add_word(ptg_pkg::CMD_CANCEL,  32'hFFFF_FFFF, 1, 0, 16'd0, 0);
    add_word(ptg_pkg::CMD_SERVICE, 32'h0000_0005, 1, 0, 16'd0, 0);

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Walk the script; registers change only with nothing in flight
    foreach (script[i]) begin
      row = script[i];
      if (row.is_cfg) begin
        drain();
        set_register(row.sel, row.value);
      end else begin
        send_word(row.op, row.tick, row.typed, row.want);
      end
    end
    drain();
    settings_used = 3;

    // Randomized phases, each with a fresh register setting
    for (int p = 0; p < PHASES; p++) begin
      mid_change = 1'b0;
      case (p)
        1: begin  // triggers ignored, wide durations
          tot = 32'd0;
          fd  = $urandom;
          ht  = $urandom;
          lt  = $urandom;
        end
        3: begin  // toggle on every poll, longest train
          tot = 32'h0000_FFFF;
          fd  = 32'd0;
          ht  = 32'd0;
          lt  = 32'd0;
        end
        4: begin  // longest durations
          tot = $urandom_range(1, 65535);
          fd  = 32'hFFFF_FFFF;
          ht  = 32'hFFFF_FFFF;
          lt  = 32'hFFFF_FFFF;
        end
        5: begin
          tot = $urandom_range(0, 65535);
          fd  = $urandom >> $urandom_range(0, 31);
          ht  = $urandom >> $urandom_range(0, 31);
          lt  = $urandom >> $urandom_range(0, 31);
        end
        default: begin  // short trains of short pulses
          tot = $urandom_range(1, 6);
          fd  = $urandom_range(0, 15);
          ht  = $urandom_range(0, 15);
          lt  = $urandom_range(0, 15);
          mid_change = 1'b1;
        end
      endcase
      tx_calm = (p == 2 || p == 6);
      rx_calm = (p == 2);

      set_register(ptg_pkg::REG_CYCLE_TOTAL, tot);
      set_register(ptg_pkg::REG_FIRST_DELAY, fd);
      set_register(ptg_pkg::REG_HIGH_TIME,   ht);
      set_register(ptg_pkg::REG_LOW_TIME,    lt);
      settings_used++;

      // start some phases just below the wrap of the tick
      tick_now = $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(0, 200) : $urandom;
      if (p == 6)
        squeeze_req = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (mid_change && n == PHASE_ITEMS / 2) begin
          // retune one register in the middle of whatever train is running
          drain();
          pick = ptg_pkg::reg_e'($urandom_range(3));
          set_register(pick, (pick == ptg_pkg::REG_CYCLE_TOTAL) ? $urandom_range(1, 4)
                                                                : $urandom_range(0, 12));
          settings_used++;
        end
        r = $urandom_range(99);
        tick_now = tick_now + $urandom_range(0, 6);
        if (!trn_running && r < 40)
          op = ptg_pkg::CMD_TRIGGER;
        else if (r < 88)
          op = ptg_pkg::CMD_SERVICE;
        else if (r < 91)
          op = ptg_pkg::CMD_TRIGGER;
        else if (r < 93)
          op = ptg_pkg::CMD_CANCEL;
        else if (r < 96)
          op = CMD_UNUSED;
        else begin
          // jump the tick anywhere
          op       = ptg_pkg::CMD_SERVICE;
          tick_now = $urandom;
        end
        send_word(op, tick_now, 1'b0, '0);
      end
      drain();
    end

    // Let any straggler show up before the verdict
    repeat (TAIL_TICKS) @(posedge clk_i);

    $display("Run covered %0d command words and %0d result words over %0d register settings,",
             words_in, words_out, settings_used);
    $display("with %0d level toggles and %0d cycles of input back-pressure.",
             toggles_seen, stall_cycles);
    if (errors == 0 && pulse_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d errors, %0d result words never arrived", errors, pulse_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
